/* src/fsba_pkg.sv */
// ----------------------------------------------------------------------------
// Fit-strategy block allocator package
// Sequencer states, placement policy codes, register indexes and item modes.
// ----------------------------------------------------------------------------
`default_nettype none

package fsba_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } fsba_state_e;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  localparam logic [0:0] REG_POLICY = 1'b0;
  localparam logic [0:0] REG_BLOCKS = 1'b1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  localparam logic [4:0] BLOCKS_RESET = 5'd16;

endpackage

`default_nettype wire

/* src/fsba_ram.sv */
// ----------------------------------------------------------------------------
// Fit-strategy block allocator RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fsba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/fit_strategy_block_allocator.sv */
// ----------------------------------------------------------------------------
// Fit-strategy block allocator
// Keeps the free space of each block in a RAM and places requests by first,
// next, best or worst fit. A load word passes through the hand-off state to
// the output register. An allocate word walks the single read port of the
// free-space RAM one entry a cycle over the n active blocks, followed by a
// write-back state (skipped when nothing fits) and the hand-off state; first
// and next fit finish early on a hit. With no active block an allocate word
// goes straight to hand-off. Entries read as zero until first loaded, so no
// clearing pass is needed after reset. A new word is taken once the previous
// one has been handed to the output register, even if that result still
// waits.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_strategy_block_allocator
  import fsba_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [3:0]  block_index_i,
  input  wire logic [15:0] amount_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             granted_o,
  output logic [3:0]       chosen_block_o,
  output logic [15:0]      space_left_o
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  fsba_state_e state_q, state_d;

  logic [1:0]            policy_q;
  logic [4:0]            blocks_q;
  logic [IDX_W-1:0]      rover_q;
  logic [NUM_BLOCKS-1:0] vld_q;
  logic [CNT_W-1:0]      n_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [IDX_W-1:0]      pos_q;
  logic [SIZE_BITS-1:0]  amt_q;
  logic                  rd_pend_q;
  logic [IDX_W-1:0]      rd_addr_q;
  logic                  rd_vld_q;
  logic                  have_q;
  logic [IDX_W-1:0]      pick_q;
  logic [SIZE_BITS-1:0]  pick_val_q;
  logic                  res_granted_q;
  logic [3:0]            res_block_q;
  logic [15:0]           res_space_q;
  logic                  out_valid_q;
  logic                  out_granted_q;
  logic [3:0]            out_block_q;
  logic [15:0]           out_space_q;

  logic [31:0]          amt_ext;
  logic [SIZE_BITS-1:0] amt_in;
  logic [31:0]          amt_in_ext;
  logic [31:0]          idx_ext;
  logic                 load_ok;
  logic [IDX_W-1:0]     load_addr;
  logic [CNT_W-1:0]     n_act;
  logic [IDX_W-1:0]     start_pos;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 fits;
  logic                 better;
  logic                 upd;
  logic                 have_n;
  logic                 issue;
  logic [IDX_W-1:0]     pos_nx;
  logic                 out_free;
  logic                 in_acc;
  logic                 early;
  logic [SIZE_BITS-1:0] wr_val;
  logic [31:0]          wr_ext;
  logic [31:0]          pick_ext;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;

  assign amt_ext    = 32'(amount_i);
  assign amt_in     = amt_ext[SIZE_BITS-1:0];
  assign amt_in_ext = 32'(amt_in);
  assign idx_ext    = 32'(block_index_i);
  assign load_ok    = idx_ext < 32'(NUM_BLOCKS);
  assign load_addr  = idx_ext[IDX_W-1:0];
  assign n_act      = (32'(blocks_q) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(blocks_q);
  assign start_pos  = (policy_q == POL_NEXT && 32'(rover_q) < 32'(n_act)) ? rover_q : '0;

  assign rd_data = rd_vld_q ? ram_rdata : '0;
  assign fits    = rd_pend_q && (rd_data >= amt_q);
  assign better  = !have_q || (policy_q == POL_BEST && rd_data < pick_val_q) ||
                   (policy_q == POL_WORST && rd_data > pick_val_q);
  assign upd     = fits && better;
  assign have_n  = have_q || upd;
  assign early   = (policy_q == POL_FIRST || policy_q == POL_NEXT) && fits;

  assign issue  = (state_q == ST_SCAN) && (cnt_q != n_q);
  assign pos_nx = (32'(pos_q) + 32'd1 == 32'(n_q)) ? '0 : pos_q + 1'b1;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign wr_val   = pick_val_q - amt_q;
  assign wr_ext   = 32'(wr_val);
  assign pick_ext = 32'(pick_q);

  assign ram_we    = (in_acc && mode_i == MODE_LOAD && load_ok) || (state_q == ST_WRITE);
  assign ram_waddr = (state_q == ST_WRITE) ? pick_q : load_addr;
  assign ram_wdata = (state_q == ST_WRITE) ? wr_val : amt_in;

  fsba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_i == MODE_LOAD || n_act == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        priority if (early) begin
          state_d = ST_WRITE;
        end else if (!issue && rd_pend_q) begin
          state_d = have_n ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= POL_FIRST;
      blocks_q    <= BLOCKS_RESET;
      rover_q     <= '0;
      vld_q       <= '0;
      rd_pend_q   <= 1'b0;
      have_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_POLICY: policy_q <= cfg_wdata_i[1:0];
          REG_BLOCKS: blocks_q <= cfg_wdata_i;
          default:    policy_q <= policy_q;
        endcase
      end
      if (in_acc && mode_i == MODE_LOAD && load_ok) begin
        rover_q          <= '0;
        vld_q[load_addr] <= 1'b1;
      end
      if (state_q == ST_WRITE) begin
        vld_q[pick_q] <= 1'b1;
        if (policy_q == POL_NEXT) begin
          rover_q <= pick_q;
        end
      end
      if (in_acc) begin
        cnt_q     <= '0;
        have_q    <= 1'b0;
        rd_pend_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        rd_pend_q <= issue && (state_d == ST_SCAN);
        have_q    <= have_n;
        if (issue) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      n_q   <= n_act;
      pos_q <= start_pos;
      amt_q <= amt_in;
      if (mode_i == MODE_LOAD) begin
        res_granted_q <= load_ok;
        res_block_q   <= block_index_i;
        res_space_q   <= load_ok ? amt_in_ext[15:0] : '0;
      end else begin
        res_granted_q <= 1'b0;
        res_block_q   <= '0;
        res_space_q   <= '0;
      end
    end
    if (state_q == ST_SCAN) begin
      rd_addr_q <= pos_q;
      rd_vld_q  <= vld_q[pos_q];
      if (issue) begin
        pos_q <= pos_nx;
      end
      if (upd) begin
        pick_q     <= rd_addr_q;
        pick_val_q <= rd_data;
      end
    end
    if (state_q == ST_WRITE) begin
      res_granted_q <= 1'b1;
      res_block_q   <= pick_ext[3:0];
      res_space_q   <= wr_ext[15:0];
    end
    if (state_q == ST_DONE && out_free) begin
      out_granted_q <= res_granted_q;
      out_block_q   <= res_block_q;
      out_space_q   <= res_space_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_o      = out_granted_q;
  assign chosen_block_o = out_block_q;
  assign space_left_o   = out_space_q;

  a_write_has_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> have_q)
    else $error("write-back without a chosen block");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= n_q))
    else $error("scan counter beyond active block count");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_SCAN))
    else $error("read pending outside the scan");

  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE || state_q == ST_WRITE))
    else $error("RAM written during scan or hand-off");

  a_done_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_valid_q)
    else $error("result not handed to output register");

endmodule

`default_nettype wire
